// ===== sv/etr_pkg.sv =====
// etr_pkg: shared types and constants for the event-to-task channel router
// request codes, payload words, controller/datapath interface structs
// no dependencies
package etr_pkg;

  localparam int ID_W     = 6;
  localparam int REQ_W    = 4;
  localparam int CHAN_W   = 5;
  localparam int MASK_W   = 32;
  localparam int GROUP_W  = 3;
  localparam int CFG_IDX_W = 3;
  localparam int FIXED_TABLE_DEPTH = 32;

  typedef enum logic [REQ_W-1:0] {
    REQ_RAISE    = 4'd0,
    REQ_SET_SRC  = 4'd1,
    REQ_SET_TASK = 4'd2,
    REQ_SET_FORK = 4'd3,
    REQ_WRITE_EN = 4'd4,
    REQ_SET_BITS = 4'd5,
    REQ_CLR_BITS = 4'd6,
    REQ_GRP_ON   = 4'd7,
    REQ_GRP_OFF  = 4'd8,
    REQ_READ     = 4'd9
  } req_code_t;

  localparam logic KIND_TRIGGER  = 1'b0;
  localparam logic KIND_READBACK = 1'b1;

  // fixed routes, indexed by absolute channel number
  localparam logic [ID_W-1:0] FIXED_SRC [FIXED_TABLE_DEPTH] = '{
    6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
    6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
    6'd7, 6'd7, 6'd8, 6'd6, 6'd1, 6'd2, 6'd2, 6'd4, 6'd20, 6'd20,
    6'd20, 6'd20
  };
  localparam logic [ID_W-1:0] FIXED_TSK [FIXED_TABLE_DEPTH] = '{
    6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
    6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
    6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd1, 6'd2,
    6'd9, 6'd10
  };

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [CHAN_W-1:0]  channel;
    logic [ID_W-1:0]    event_id;
    logic [ID_W-1:0]    task_id;
    logic [MASK_W-1:0]  mask;
    logic [GROUP_W-1:0] group;
  } etr_req_t;

  typedef struct packed {
    logic              kind;
    logic [ID_W-1:0]   trigger_task;
    logic [MASK_W-1:0] enable_value;
    logic              is_last;
  } etr_rsp_t;

  typedef struct packed {
    logic load;       // capture accepted request
    logic exec;       // apply request, build pending trigger set
    logic emit_read;  // load readback word
    logic emit_trig;  // load next trigger word
  } etr_cmd_t;

  typedef struct packed {
    logic is_event;
    logic is_read;
    logic pend_empty;
    logic pend_last;
  } etr_stat_t;

endpackage

// ===== sv/etr_ctrl.sv =====
// etr_ctrl: sequencing state machine of the router
// issues commands to etr_dpath, owns the response valid flag
// depends on etr_pkg
module etr_ctrl import etr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  input  etr_stat_t stat,
  output etr_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN
  } state_t;

  state_t state;
  state_t state_next;
  logic   rsp_valid_next;
  logic   out_free;

  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == ST_IDLE);

  always_comb begin
    cmd.load      = (state == ST_IDLE) && req_valid;
    cmd.exec      = (state == ST_EXEC) && !stat.is_read;
    cmd.emit_read = (state == ST_EXEC) && stat.is_read && out_free;
    cmd.emit_trig = (state == ST_SCAN) && !stat.pend_empty && out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        priority if (stat.is_read) begin
          if (out_free) state_next = ST_IDLE;
        end else if (stat.is_event) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        priority if (stat.pend_empty) begin
          state_next = ST_IDLE;
        end else if (out_free && stat.pend_last) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_SCAN;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.emit_read || cmd.emit_trig) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

// ===== sv/etr_dpath.sv =====
// etr_dpath: channel tables, enable mask, group masks, trigger scan, response register
// driven by commands from etr_ctrl
// depends on etr_pkg
module etr_dpath import etr_pkg::*; #(
  parameter int NUM_CHANNELS      = 32,
  parameter int NUM_PROG_CHANNELS = 20,
  parameter int NUM_GROUPS        = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  etr_cmd_t             cmd,
  output etr_stat_t            stat,
  input  etr_req_t             req,
  output etr_rsp_t             rsp,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MASK_W-1:0]    cfg_data
);

  localparam int PEND_W = 2 * NUM_CHANNELS;

  etr_req_t                req_q;
  logic [ID_W-1:0]         src [NUM_CHANNELS];
  logic [ID_W-1:0]         tsk [NUM_CHANNELS];
  logic [ID_W-1:0]         frk [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] en;
  logic [MASK_W-1:0]       grp_mask [NUM_GROUPS];
  logic [PEND_W-1:0]       pend;
  logic [PEND_W-1:0]       pend_next;
  logic [PEND_W-1:0]       low_bit;
  logic [PEND_W-1:0]       pend_rest;
  logic [ID_W-1:0]         pick_id;
  logic [NUM_CHANNELS-1:0] grp_sel;
  logic [NUM_CHANNELS-1:0] req_m;
  logic [NUM_CHANNELS-1:0] ch_hit;

  assign req_m = req_q.mask[NUM_CHANNELS-1:0];

  // selected channels, two slots each: task then fork
  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      logic sel;
      sel = en[i] && (src[i] == req_q.event_id) && (req_q.event_id != '0);
      pend_next[2*i]   = sel && (tsk[i] != '0);
      pend_next[2*i+1] = sel && (frk[i] != '0);
    end
  end

  // lowest pending slot and its id
  assign low_bit   = pend & (~pend + PEND_W'(1));
  assign pend_rest = pend & ~low_bit;

  always_comb begin
    pick_id = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      pick_id = pick_id | ({ID_W{low_bit[2*i]}} & tsk[i])
                        | ({ID_W{low_bit[2*i+1]}} & frk[i]);
    end
  end

  always_comb begin
    grp_sel = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      if (req_q.group == GROUP_W'(g)) grp_sel = grp_mask[g][NUM_CHANNELS-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      ch_hit[i] = (req_q.channel == CHAN_W'(i));
    end
  end

  always_comb begin
    stat.is_event   = (req_q.req_type == REQ_RAISE);
    stat.is_read    = (req_q.req_type == REQ_READ);
    stat.pend_empty = (pend == '0);
    stat.pend_last  = (pend_rest == '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) req_q <= req;

    if (cmd.emit_read) begin
      rsp.kind         <= KIND_READBACK;
      rsp.trigger_task <= '0;
      rsp.enable_value <= MASK_W'(en);
      rsp.is_last      <= 1'b1;
    end else if (cmd.emit_trig) begin
      rsp.kind         <= KIND_TRIGGER;
      rsp.trigger_task <= pick_id;
      rsp.enable_value <= '0;
      rsp.is_last      <= (pend_rest == '0);
    end

    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        src[i] <= (i >= NUM_PROG_CHANNELS) ? FIXED_SRC[i] : '0;
        tsk[i] <= (i >= NUM_PROG_CHANNELS) ? FIXED_TSK[i] : '0;
        frk[i] <= '0;
      end
      for (int g = 0; g < NUM_GROUPS; g++) begin
        grp_mask[g] <= '0;
      end
      en   <= '0;
      pend <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
          if (cfg_index == CFG_IDX_W'(g)) grp_mask[g] <= cfg_data;
        end
      end

      if (cmd.exec) begin
        unique case (req_q.req_type)
          REQ_RAISE: pend <= pend_next;
          REQ_SET_SRC: begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
              if (i < NUM_PROG_CHANNELS && ch_hit[i]) src[i] <= req_q.event_id;
            end
          end
          REQ_SET_TASK: begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
              if (i < NUM_PROG_CHANNELS && ch_hit[i]) tsk[i] <= req_q.task_id;
            end
          end
          REQ_SET_FORK: begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
              if (ch_hit[i]) frk[i] <= req_q.task_id;
            end
          end
          REQ_WRITE_EN: en <= req_m;
          REQ_SET_BITS: en <= en | req_m;
          REQ_CLR_BITS: en <= en & ~req_m;
          REQ_GRP_ON:   en <= en | grp_sel;
          REQ_GRP_OFF:  en <= en & ~grp_sel;
          default: ;
        endcase
      end else if (cmd.emit_trig) begin
        pend <= pend_rest;
      end
    end
  end

endmodule

// ===== sv/event_to_task_channel_router.sv =====
// event_to_task_channel_router: one request word in, zero or more response words out
// a non-event request passes accept and execute; a readback word is loaded in
//   execute once the output is free. an event passes accept, execute and scan,
//   one trigger word per cycle from the pending-slot scan while the output is free
// reset: synchronous, clears enables, group masks, fork tasks; restores fixed routes
module event_to_task_channel_router import etr_pkg::*; #(
  parameter int NUM_CHANNELS      = 32,
  parameter int NUM_PROG_CHANNELS = 20,
  parameter int NUM_GROUPS        = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  // request words
  input  logic                 req_valid,
  output logic                 req_ready,
  input  etr_req_t             req,
  // response words: task triggers and enable readback
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output etr_rsp_t             rsp,
  // group mask register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MASK_W-1:0]    cfg_data
);

  etr_cmd_t  cmd;
  etr_stat_t stat;

  // group masks are plain registers, always writable
  assign cfg_ready = 1'b1;

  // sequencer: idle -> execute -> scan (events only) -> idle
  etr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // channel tables, enable mask and the response register
  etr_dpath #(
    .NUM_CHANNELS      (NUM_CHANNELS),
    .NUM_PROG_CHANNELS (NUM_PROG_CHANNELS),
    .NUM_GROUPS        (NUM_GROUPS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .req       (req),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // a trigger word never carries the none id
  a_trig_nonzero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.kind == KIND_TRIGGER) |-> (rsp.trigger_task != '0))
    else $error("trigger word with zero task id");

  // a readback is a single word, marked last, with no task id
  a_read_word: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_read |=> rsp_valid && rsp.is_last && (rsp.kind == KIND_READBACK)
                      && (rsp.trigger_task == '0))
    else $error("readback word malformed");

  // one request in flight: no accept directly after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while previous one executes");

  // loading a request never overlaps executing one or emitting a word
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !(cmd.emit_read || cmd.emit_trig || cmd.exec))
    else $error("request load overlaps execute or emit");

endmodule
